// File: src/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg
// Shared constants and types for the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL_MAX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_MIN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     shl;
    logic signed [DATA_W-1:0] value;
  } depq_op_t;

endpackage

// File: src/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded sorted multiset of signed words held in a row of cells.
// ----------------------------------------------------------------------------
// The result strobe follows acceptance of a word through busy_q and then valid_q.
// A new word is not accepted while busy is high; first the cell row updates,
//   then the top cell is selected for the maximum and the result is registered.
// Reset clears occupancy and the handshake; cell contents are not cleared.
// The receiver cannot stall: each result stands for exactly one cycle.
module double_ended_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [depq_pkg::KIND_W-1:0]         kind_i,
  input  logic signed [depq_pkg::DATA_W-1:0]  value_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output logic                                is_empty_o,
  output logic signed [depq_pkg::DATA_W-1:0]  largest_o,
  output logic signed [depq_pkg::DATA_W-1:0]  smallest_o,
  output logic                                dropped_o
);

  localparam int N = depq_pkg::CAPACITY;

  logic                          accept;
  logic                          full;
  logic                          empty;
  depq_pkg::depq_op_t            op;
  logic [depq_pkg::OCC_W-1:0]    occ_q, occ_d;
  logic                          busy_q;
  logic                          drop_q;
  logic                          valid_q;
  logic                          is_empty_q;
  logic signed [depq_pkg::DATA_W-1:0] largest_q, smallest_q;
  logic                          dropped_q;
  logic signed [depq_pkg::DATA_W-1:0] top_sel;

  logic signed [depq_pkg::DATA_W-1:0] data [N];
  logic [N-1:0]                  gt;

  assign accept = start_i && !busy_q;
  assign full   = (occ_q == depq_pkg::OCC_W'(N));
  assign empty  = (occ_q == '0);

  always_comb begin
    op.value = value_i;
    op.ins   = accept && (kind_i == depq_pkg::KIND_INSERT) && !full;
    op.shl   = accept && (kind_i == depq_pkg::KIND_DEL_MIN) && !empty;
  end

  always_comb begin
    occ_d = occ_q;
    if (accept) begin
      case (kind_i)
        depq_pkg::KIND_INSERT:  if (!full)  occ_d = occ_q + 1'b1;
        depq_pkg::KIND_DEL_MAX: if (!empty) occ_d = occ_q - 1'b1;
        depq_pkg::KIND_DEL_MIN: if (!empty) occ_d = occ_q - 1'b1;
        depq_pkg::KIND_CLEAR:   occ_d = '0;
        default:                occ_d = occ_q;
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [depq_pkg::DATA_W-1:0] left_data;
    logic signed [depq_pkg::DATA_W-1:0] right_data;
    logic                               left_gt;
    logic                               beyond;

    assign beyond = (occ_q <= depq_pkg::OCC_W'(i));

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_gt   = 1'b0;
    end else begin : g_mid
      assign left_data = data[i-1];
      assign left_gt   = gt[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_data = data[i];
    end else begin : g_inner
      assign right_data = data[i+1];
    end

    depq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .beyond_i     (beyond),
      .left_data_i  (left_data),
      .left_gt_i    (left_gt),
      .right_data_i (right_data),
      .data_o       (data[i]),
      .gt_o         (gt[i])
    );
  end

  // one-hot pick of the highest occupied cell
  always_comb begin
    top_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (occ_q == depq_pkg::OCC_W'(i + 1)) begin
        top_sel = top_sel | data[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      busy_q  <= accept;
      valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drop_q <= (kind_i == depq_pkg::KIND_INSERT) && full;
    end
    if (busy_q) begin
      is_empty_q <= empty;
      largest_q  <= empty ? '0 : top_sel;
      smallest_q <= empty ? '0 : data[0];
      dropped_q  <= drop_q;
    end
  end

  assign busy_o     = busy_q;
  assign valid_o    = valid_q;
  assign is_empty_o = is_empty_q;
  assign largest_o  = largest_q;
  assign smallest_o = smallest_q;
  assign dropped_o  = dropped_q;

endmodule

// File: src/depq_cell.sv
// ----------------------------------------------------------------------------
// depq_cell
// One slot of the sorted array: holds a value, takes part in ordered insert
// (shift toward the top) and delete-minimum (shift toward slot zero).
// ----------------------------------------------------------------------------
module depq_cell (
  input  logic                              clk_i,
  input  depq_pkg::depq_op_t                op_i,
  input  logic                              beyond_i,
  input  logic signed [depq_pkg::DATA_W-1:0] left_data_i,
  input  logic                              left_gt_i,
  input  logic signed [depq_pkg::DATA_W-1:0] right_data_i,
  output logic signed [depq_pkg::DATA_W-1:0] data_o,
  output logic                              gt_o
);

  logic signed [depq_pkg::DATA_W-1:0] data_q;
  logic signed [depq_pkg::DATA_W-1:0] data_d;

  // new value belongs at or below this slot
  assign gt_o   = beyond_i || (op_i.value < data_q);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (left_gt_i) begin
        data_d = left_data_i;
      end else if (gt_o) begin
        data_d = op_i.value;
      end
    end else if (op_i.shl) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: src/depq_checker.sv
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks on the double-ended priority queue, bound to the top.
// ----------------------------------------------------------------------------
module depq_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_o,
  input  logic                                valid_o,
  input  logic                                is_empty_o,
  input  logic signed [depq_pkg::DATA_W-1:0]  largest_o,
  input  logic signed [depq_pkg::DATA_W-1:0]  smallest_o,
  input  logic                                dropped_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted word");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (valid_o && !busy_o))
    else $error("result strobe missing after busy cycle");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_empty_o) |-> (largest_o == '0 && smallest_o == '0))
    else $error("empty result with nonzero extremes");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !is_empty_o) |-> (largest_o >= smallest_o))
    else $error("maximum below minimum");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dropped_o) |-> !is_empty_o)
    else $error("drop reported on empty store");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .valid_o    (valid_o),
  .is_empty_o (is_empty_o),
  .largest_o  (largest_o),
  .smallest_o (smallest_o),
  .dropped_o  (dropped_o)
);
